@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the rtl file mlpt_ctrl.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MLPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MLPT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MLPT_ASSERT(lbl, prop, msg)
`define MLPT_NEVER(lbl, expr, msg)
`endif
`endif

@@ hw/rtl/mlpt_pkg.sv @@
// package with types, constants and helpers of the multi level page tlb
package mlpt_pkg;

    localparam int L0_DEPTH     = 4;
    localparam int L1_DEPTH     = 4;
    localparam int L2_DEPTH     = 8;
    localparam int L3_SET_COUNT = 16;
    localparam int L3_WAY_COUNT = 4;

    localparam int CTX_W          = 12;
    localparam int L1_TAG_W       = 8;
    localparam int L2_TAG_W       = 14;
    localparam int L3_TAG_W       = 20;
    localparam int L3_KEY_W       = CTX_W + L3_TAG_W;
    localparam int PTE_W          = 32;
    localparam int PADDR_W        = 36;
    localparam int ACC_GLOBAL_MIN = 6;

    localparam logic [L3_TAG_W-1:0] L1_MASK = 20'hFF000;
    localparam logic [L3_TAG_W-1:0] L2_MASK = 20'hFFFC0;
    localparam logic [L3_TAG_W-1:0] L3_MASK = 20'hFFFFF;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_UPDATE = 2'd2,
        OP_FLUSH  = 2'd3
    } op_e_t;

    typedef enum logic [2:0] {
        FL_PAGE    = 3'd0,
        FL_SEGMENT = 3'd1,
        FL_REGION  = 3'd2,
        FL_CONTEXT = 3'd3,
        FL_ENTIRE  = 3'd4
    } flush_e_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WRD,
        S_WCMP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        va;
        logic [CTX_W-1:0]   context_req;
        logic [PTE_W-1:0]   pte_value;
        logic [1:0]         level;
        logic [PADDR_W-1:0] pte_addr;
        logic [2:0]         flush_type;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [PTE_W-1:0]   found_pte;
        logic [1:0]         found_level;
        logic [PADDR_W-1:0] found_pte_addr;
    } rsp_t;

    typedef struct packed {
        logic load_req;
        logic rd_en;
        logic rd_walk;
        logic exec;
        logic walk_cmp;
        logic walk_inc;
    } cmd_t;

    typedef struct packed {
        logic walk_need;
        logic walk_last;
    } stat_t;

    function automatic logic is_global(input logic [PTE_W-1:0] pte);
        return pte[4:2] >= 3'(ACC_GLOBAL_MIN);
    endfunction

    function automatic logic [L3_TAG_W-1:0] flush_mask(input logic [2:0] ft);
        logic [L3_TAG_W-1:0] m;
        unique case (ft)
            FL_PAGE:    m = L3_MASK;
            FL_SEGMENT: m = L2_MASK;
            FL_REGION:  m = L1_MASK;
            default:    m = '0;
        endcase
        return m;
    endfunction

    function automatic logic flush_hit(input logic [2:0] ft, input logic glob,
                                       input logic ctx_eq, input logic [L3_TAG_W-1:0] va_top,
                                       input logic [L3_TAG_W-1:0] tag_top,
                                       input logic [L3_TAG_W-1:0] lvl_mask);
        logic [L3_TAG_W-1:0] m;
        logic                r;
        m = flush_mask(ft) & lvl_mask;
        if (ft == FL_CONTEXT)
            r = !glob && ctx_eq;
        else if (ft == FL_PAGE || ft == FL_SEGMENT || ft == FL_REGION)
            r = (glob || ctx_eq) && ((va_top & m) == (tag_top & m));
        else
            r = 1'b0;
        return r;
    endfunction

endpackage

@@ hw/rtl/mlpt_ctrl.sv @@
// controller state machine of the multi level page tlb
`include "assert_macros.svh"

module mlpt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  mlpt_pkg::stat_t   stat,
    output mlpt_pkg::cmd_t    cmd
);

    mlpt_pkg::state_t state_reg;
    mlpt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mlpt_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        rsp_valid  = 1'b0;
        unique case (state_reg)
            mlpt_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    cmd.rd_en    = 1'b1;
                    state_next   = mlpt_pkg::S_EXEC;
                end
            end
            mlpt_pkg::S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.walk_need ? mlpt_pkg::S_WRD : mlpt_pkg::S_DONE;
            end
            mlpt_pkg::S_WRD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_walk = 1'b1;
                state_next  = mlpt_pkg::S_WCMP;
            end
            mlpt_pkg::S_WCMP:
            begin
                cmd.walk_cmp = 1'b1;
                if (stat.walk_last)
                    state_next = mlpt_pkg::S_DONE;
                else
                begin
                    cmd.walk_inc = 1'b1;
                    state_next   = mlpt_pkg::S_WRD;
                end
            end
            mlpt_pkg::S_DONE:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                    state_next = mlpt_pkg::S_IDLE;
            end
            default:
                state_next = mlpt_pkg::S_IDLE;
        endcase
    end

    `MLPT_ASSERT(a_accept_exec, req_valid && req_ready |=> state_reg == mlpt_pkg::S_EXEC, "accepted beat not executed")
    `MLPT_ASSERT(a_exec_next, state_reg == mlpt_pkg::S_EXEC |=> state_reg == mlpt_pkg::S_DONE || state_reg == mlpt_pkg::S_WRD, "bad state after exec")
    `MLPT_ASSERT(a_walk_loop, state_reg == mlpt_pkg::S_WCMP && !stat.walk_last |=> state_reg == mlpt_pkg::S_WRD, "walk stopped early")
    `MLPT_NEVER(a_one_item, req_ready && rsp_valid, "accept while result pending")

endmodule

@@ hw/rtl/mlpt_dp.sv @@
// datapath of the multi level page tlb: entry stores, level 3 set memory, compare logic
module mlpt_dp
#(
    parameter int L0_DEPTH     = mlpt_pkg::L0_DEPTH,
    parameter int L1_DEPTH     = mlpt_pkg::L1_DEPTH,
    parameter int L2_DEPTH     = mlpt_pkg::L2_DEPTH,
    parameter int L3_SET_COUNT = mlpt_pkg::L3_SET_COUNT,
    parameter int L3_WAY_COUNT = mlpt_pkg::L3_WAY_COUNT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  mlpt_pkg::req_t   req,
    input  mlpt_pkg::cmd_t   cmd,
    output mlpt_pkg::stat_t  stat,
    output mlpt_pkg::rsp_t   rsp
);

    localparam int L0_IW = (L0_DEPTH > 1) ? $clog2(L0_DEPTH) : 1;
    localparam int L1_IW = (L1_DEPTH > 1) ? $clog2(L1_DEPTH) : 1;
    localparam int L2_IW = (L2_DEPTH > 1) ? $clog2(L2_DEPTH) : 1;
    localparam int SET_W = (L3_SET_COUNT > 1) ? $clog2(L3_SET_COUNT) : 1;
    localparam int WAY_W = (L3_WAY_COUNT > 1) ? $clog2(L3_WAY_COUNT) : 1;
    localparam int CW    = mlpt_pkg::CTX_W;
    localparam int T1    = mlpt_pkg::L1_TAG_W;
    localparam int T2    = mlpt_pkg::L2_TAG_W;
    localparam int T3    = mlpt_pkg::L3_TAG_W;
    localparam int KW    = mlpt_pkg::L3_KEY_W;
    localparam int PW    = mlpt_pkg::PTE_W;
    localparam int AW    = mlpt_pkg::PADDR_W;

    mlpt_pkg::req_t req_reg;
    mlpt_pkg::rsp_t rsp_reg;
    mlpt_pkg::rsp_t rsp_c;

    logic [L0_DEPTH-1:0] l0_vld_reg;
    logic [CW-1:0]       l0_ctx_reg  [L0_DEPTH];
    logic [PW-1:0]       l0_pte_reg  [L0_DEPTH];
    logic [AW-1:0]       l0_addr_reg [L0_DEPTH];
    logic [L0_IW-1:0]    l0_vic_reg;

    logic [L1_DEPTH-1:0] l1_vld_reg;
    logic [CW-1:0]       l1_ctx_reg  [L1_DEPTH];
    logic [T1-1:0]       l1_tag_reg  [L1_DEPTH];
    logic [PW-1:0]       l1_pte_reg  [L1_DEPTH];
    logic [AW-1:0]       l1_addr_reg [L1_DEPTH];
    logic [L1_IW-1:0]    l1_vic_reg;

    logic [L2_DEPTH-1:0] l2_vld_reg;
    logic [CW-1:0]       l2_ctx_reg  [L2_DEPTH];
    logic [T2-1:0]       l2_tag_reg  [L2_DEPTH];
    logic [PW-1:0]       l2_pte_reg  [L2_DEPTH];
    logic [AW-1:0]       l2_addr_reg [L2_DEPTH];
    logic [L2_IW-1:0]    l2_vic_reg;

    logic [L3_WAY_COUNT-1:0]         l3_vld_reg [L3_SET_COUNT];
    logic [WAY_W-1:0]                l3_vic_reg [L3_SET_COUNT];
    logic [L3_WAY_COUNT-1:0][KW-1:0] l3_key_mem  [L3_SET_COUNT];
    logic [L3_WAY_COUNT-1:0][PW-1:0] l3_pte_mem  [L3_SET_COUNT];
    logic [L3_WAY_COUNT-1:0][AW-1:0] l3_addr_mem [L3_SET_COUNT];
    logic [L3_WAY_COUNT-1:0][KW-1:0] key_row_reg;
    logic [L3_WAY_COUNT-1:0][PW-1:0] pte_row_reg;
    logic [L3_WAY_COUNT-1:0][AW-1:0] addr_row_reg;
    logic [SET_W-1:0]                walk_cnt_reg;

    logic [SET_W-1:0] rd_set;
    logic [SET_W-1:0] eset;
    logic [T1-1:0]    tag1;
    logic [T2-1:0]    tag2;
    logic [T3-1:0]    tag3;
    logic [T3-1:0]    va_top;

    logic [L0_DEPTH-1:0]     l0_m, l0_fl;
    logic [L1_DEPTH-1:0]     l1_m, l1_fl;
    logic [L2_DEPTH-1:0]     l2_m, l2_fl;
    logic [L3_WAY_COUNT-1:0] l3_m, l3_wfl;
    logic [L0_IW-1:0]        l0_idx, l0_free, l0_slot;
    logic [L1_IW-1:0]        l1_idx, l1_free, l1_slot;
    logic [L2_IW-1:0]        l2_idx, l2_free, l2_slot;
    logic [WAY_W-1:0]        l3_idx, l3_free, l3_slot;
    logic                    l3_full;

    logic [L3_WAY_COUNT-1:0][KW-1:0] key_wrow;
    logic [L3_WAY_COUNT-1:0][PW-1:0] pte_wrow;
    logic [L3_WAY_COUNT-1:0][AW-1:0] addr_wrow;
    logic                            l3_key_we;
    logic                            l3_pte_we;

    logic is_lookup, is_insert, is_update, is_flush, fl_entire, fl_part;

    assign tag1   = req_reg.va[31:24];
    assign tag2   = req_reg.va[31:18];
    assign tag3   = req_reg.va[31:12];
    assign va_top = req_reg.va[31:12];
    assign eset   = SET_W'(req_reg.va[31:12] % L3_SET_COUNT);
    assign rd_set = cmd.rd_walk ? walk_cnt_reg : SET_W'(req.va[31:12] % L3_SET_COUNT);

    assign is_lookup = req_reg.op == mlpt_pkg::OP_LOOKUP;
    assign is_insert = req_reg.op == mlpt_pkg::OP_INSERT;
    assign is_update = req_reg.op == mlpt_pkg::OP_UPDATE;
    assign is_flush  = req_reg.op == mlpt_pkg::OP_FLUSH;
    assign fl_entire = is_flush && req_reg.flush_type == mlpt_pkg::FL_ENTIRE;
    assign fl_part   = is_flush && req_reg.flush_type <= mlpt_pkg::FL_CONTEXT;

    assign stat.walk_need = fl_part;
    assign stat.walk_last = walk_cnt_reg == SET_W'(L3_SET_COUNT - 1);
    assign rsp            = rsp_reg;

    always_comb
    begin
        l0_idx = '0; l0_free = '0;
        l1_idx = '0; l1_free = '0;
        l2_idx = '0; l2_free = '0;
        l3_idx = '0; l3_free = '0;
        for (int i = 0; i < L0_DEPTH; i++)
        begin
            l0_m[i]  = l0_vld_reg[i] && l0_ctx_reg[i] == req_reg.context_req;
            l0_fl[i] = l0_vld_reg[i] && mlpt_pkg::flush_hit(req_reg.flush_type,
                       mlpt_pkg::is_global(l0_pte_reg[i]), l0_ctx_reg[i] == req_reg.context_req,
                       va_top, '0, '0);
        end
        for (int i = 0; i < L1_DEPTH; i++)
        begin
            l1_m[i]  = l1_vld_reg[i] && l1_ctx_reg[i] == req_reg.context_req
                       && l1_tag_reg[i] == tag1;
            l1_fl[i] = l1_vld_reg[i] && mlpt_pkg::flush_hit(req_reg.flush_type,
                       mlpt_pkg::is_global(l1_pte_reg[i]), l1_ctx_reg[i] == req_reg.context_req,
                       va_top, {l1_tag_reg[i], 12'h000}, mlpt_pkg::L1_MASK);
        end
        for (int i = 0; i < L2_DEPTH; i++)
        begin
            l2_m[i]  = l2_vld_reg[i] && l2_ctx_reg[i] == req_reg.context_req
                       && l2_tag_reg[i] == tag2;
            l2_fl[i] = l2_vld_reg[i] && mlpt_pkg::flush_hit(req_reg.flush_type,
                       mlpt_pkg::is_global(l2_pte_reg[i]), l2_ctx_reg[i] == req_reg.context_req,
                       va_top, {l2_tag_reg[i], 6'h00}, mlpt_pkg::L2_MASK);
        end
        for (int w = 0; w < L3_WAY_COUNT; w++)
        begin
            l3_m[w]   = l3_vld_reg[eset][w] && key_row_reg[w] == {req_reg.context_req, tag3};
            l3_wfl[w] = l3_vld_reg[walk_cnt_reg][w] && mlpt_pkg::flush_hit(
                        req_reg.flush_type, mlpt_pkg::is_global(pte_row_reg[w]),
                        key_row_reg[w][KW-1:T3] == req_reg.context_req,
                        va_top, key_row_reg[w][T3-1:0], mlpt_pkg::L3_MASK);
        end
        for (int i = L0_DEPTH - 1; i >= 0; i--)
        begin
            if (l0_m[i]) l0_idx = L0_IW'(i);
            if (!l0_vld_reg[i]) l0_free = L0_IW'(i);
        end
        for (int i = L1_DEPTH - 1; i >= 0; i--)
        begin
            if (l1_m[i]) l1_idx = L1_IW'(i);
            if (!l1_vld_reg[i]) l1_free = L1_IW'(i);
        end
        for (int i = L2_DEPTH - 1; i >= 0; i--)
        begin
            if (l2_m[i]) l2_idx = L2_IW'(i);
            if (!l2_vld_reg[i]) l2_free = L2_IW'(i);
        end
        for (int w = L3_WAY_COUNT - 1; w >= 0; w--)
        begin
            if (l3_m[w]) l3_idx = WAY_W'(w);
            if (!l3_vld_reg[eset][w]) l3_free = WAY_W'(w);
        end
        l0_slot = (&l0_vld_reg) ? l0_vic_reg : l0_free;
        l1_slot = (&l1_vld_reg) ? l1_vic_reg : l1_free;
        l2_slot = (&l2_vld_reg) ? l2_vic_reg : l2_free;
        l3_full = &l3_vld_reg[eset];
        l3_slot = l3_full ? l3_vic_reg[eset] : l3_free;

        rsp_c = '0;
        if (is_lookup)
        begin
            priority if (|l0_m)
            begin
                rsp_c.hit = 1'b1; rsp_c.found_level = 2'd0;
                rsp_c.found_pte = l0_pte_reg[l0_idx]; rsp_c.found_pte_addr = l0_addr_reg[l0_idx];
            end
            else if (|l1_m)
            begin
                rsp_c.hit = 1'b1; rsp_c.found_level = 2'd1;
                rsp_c.found_pte = l1_pte_reg[l1_idx]; rsp_c.found_pte_addr = l1_addr_reg[l1_idx];
            end
            else if (|l2_m)
            begin
                rsp_c.hit = 1'b1; rsp_c.found_level = 2'd2;
                rsp_c.found_pte = l2_pte_reg[l2_idx]; rsp_c.found_pte_addr = l2_addr_reg[l2_idx];
            end
            else if (|l3_m)
            begin
                rsp_c.hit = 1'b1; rsp_c.found_level = 2'd3;
                rsp_c.found_pte = pte_row_reg[l3_idx]; rsp_c.found_pte_addr = addr_row_reg[l3_idx];
            end
        end

        key_wrow  = key_row_reg;
        pte_wrow  = pte_row_reg;
        addr_wrow = addr_row_reg;
        l3_key_we = cmd.exec && is_insert && req_reg.level == 2'd3;
        l3_pte_we = cmd.exec && is_update && req_reg.level == 2'd3 && (|l3_m);
        if (l3_key_we)
        begin
            key_wrow[l3_slot]  = {req_reg.context_req, tag3};
            pte_wrow[l3_slot]  = req_reg.pte_value;
            addr_wrow[l3_slot] = req_reg.pte_addr;
        end
        else
            pte_wrow[l3_idx] = req_reg.pte_value;
    end

    // valid bits, victims and walk counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l0_vld_reg   <= '0;
            l1_vld_reg   <= '0;
            l2_vld_reg   <= '0;
            l0_vic_reg   <= '0;
            l1_vic_reg   <= '0;
            l2_vic_reg   <= '0;
            walk_cnt_reg <= '0;
            for (int s = 0; s < L3_SET_COUNT; s++)
            begin
                l3_vld_reg[s] <= '0;
                l3_vic_reg[s] <= '0;
            end
        end
        else if (cmd.exec)
        begin
            walk_cnt_reg <= '0;
            if (is_insert)
            begin
                unique case (req_reg.level)
                    2'd0:
                    begin
                        l0_vld_reg[l0_slot] <= 1'b1;
                        if (&l0_vld_reg)
                            l0_vic_reg <= (l0_slot == L0_IW'(L0_DEPTH - 1)) ? '0 : l0_slot + 1'b1;
                    end
                    2'd1:
                    begin
                        l1_vld_reg[l1_slot] <= 1'b1;
                        if (&l1_vld_reg)
                            l1_vic_reg <= (l1_slot == L1_IW'(L1_DEPTH - 1)) ? '0 : l1_slot + 1'b1;
                    end
                    2'd2:
                    begin
                        l2_vld_reg[l2_slot] <= 1'b1;
                        if (&l2_vld_reg)
                            l2_vic_reg <= (l2_slot == L2_IW'(L2_DEPTH - 1)) ? '0 : l2_slot + 1'b1;
                    end
                    default:
                    begin
                        l3_vld_reg[eset][l3_slot] <= 1'b1;
                        if (l3_full)
                            l3_vic_reg[eset] <= (l3_slot == WAY_W'(L3_WAY_COUNT - 1)) ?
                                                '0 : l3_slot + 1'b1;
                    end
                endcase
            end
            else if (fl_entire)
            begin
                l0_vld_reg <= '0;
                l1_vld_reg <= '0;
                l2_vld_reg <= '0;
                l0_vic_reg <= '0;
                l1_vic_reg <= '0;
                l2_vic_reg <= '0;
                for (int s = 0; s < L3_SET_COUNT; s++)
                begin
                    l3_vld_reg[s] <= '0;
                    l3_vic_reg[s] <= '0;
                end
            end
            else if (fl_part)
            begin
                l0_vld_reg <= l0_vld_reg & ~l0_fl;
                l1_vld_reg <= l1_vld_reg & ~l1_fl;
                l2_vld_reg <= l2_vld_reg & ~l2_fl;
            end
        end
        else if (cmd.walk_cmp)
        begin
            l3_vld_reg[walk_cnt_reg] <= l3_vld_reg[walk_cnt_reg] & ~l3_wfl;
            if (cmd.walk_inc)
                walk_cnt_reg <= walk_cnt_reg + 1'b1;
        end
    end

    // request, entry payload and result
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
            req_reg <= req;
        if (cmd.exec)
        begin
            rsp_reg <= rsp_c;
            if (is_insert)
            begin
                unique case (req_reg.level)
                    2'd0:
                    begin
                        l0_ctx_reg[l0_slot]  <= req_reg.context_req;
                        l0_pte_reg[l0_slot]  <= req_reg.pte_value;
                        l0_addr_reg[l0_slot] <= req_reg.pte_addr;
                    end
                    2'd1:
                    begin
                        l1_ctx_reg[l1_slot]  <= req_reg.context_req;
                        l1_tag_reg[l1_slot]  <= tag1;
                        l1_pte_reg[l1_slot]  <= req_reg.pte_value;
                        l1_addr_reg[l1_slot] <= req_reg.pte_addr;
                    end
                    2'd2:
                    begin
                        l2_ctx_reg[l2_slot]  <= req_reg.context_req;
                        l2_tag_reg[l2_slot]  <= tag2;
                        l2_pte_reg[l2_slot]  <= req_reg.pte_value;
                        l2_addr_reg[l2_slot] <= req_reg.pte_addr;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (is_update)
            begin
                unique case (req_reg.level)
                    2'd0:    if (|l0_m) l0_pte_reg[l0_idx] <= req_reg.pte_value;
                    2'd1:    if (|l1_m) l1_pte_reg[l1_idx] <= req_reg.pte_value;
                    2'd2:    if (|l2_m) l2_pte_reg[l2_idx] <= req_reg.pte_value;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // level 3 set memory, one row per set
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            key_row_reg  <= l3_key_mem[rd_set];
            pte_row_reg  <= l3_pte_mem[rd_set];
            addr_row_reg <= l3_addr_mem[rd_set];
        end
        if (l3_key_we)
        begin
            l3_key_mem[eset]  <= key_wrow;
            l3_addr_mem[eset] <= addr_wrow;
        end
        if (l3_key_we || l3_pte_we)
            l3_pte_mem[eset] <= pte_wrow;
    end

endmodule

@@ hw/rtl/multi_level_page_tlb.sv @@
// top level of the multi level page tlb
// flush of page, segment, region or context also walks every level 3 set, with one set read
// and one set compare per level 3 set through the single set memory port
// the next request is taken only after the result beat of the last one is accepted
// reset: valid bits and victim pointers clear at once, no clearing pass
module multi_level_page_tlb
#(
    parameter int L0_DEPTH     = mlpt_pkg::L0_DEPTH,
    parameter int L1_DEPTH     = mlpt_pkg::L1_DEPTH,
    parameter int L2_DEPTH     = mlpt_pkg::L2_DEPTH,
    parameter int L3_SET_COUNT = mlpt_pkg::L3_SET_COUNT,
    parameter int L3_WAY_COUNT = mlpt_pkg::L3_WAY_COUNT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  mlpt_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output mlpt_pkg::rsp_t  rsp
);

    mlpt_pkg::cmd_t  cmd;
    mlpt_pkg::stat_t stat;

    mlpt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mlpt_dp
    #(
        .L0_DEPTH     (L0_DEPTH),
        .L1_DEPTH     (L1_DEPTH),
        .L2_DEPTH     (L2_DEPTH),
        .L3_SET_COUNT (L3_SET_COUNT),
        .L3_WAY_COUNT (L3_WAY_COUNT)
    )
    u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

@@ tb/testbench.sv @@
// testbench for multi_level_page_tlb: directed table and random traffic checked against table or predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        mlpt_pkg::req_t beat;
        bit             typed;
        mlpt_pkg::rsp_t want;
    } stim_row_t;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    mlpt_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_ready;
    mlpt_pkg::rsp_t rsp;

    mlpt_pkg::rsp_t expected_rsp_q[$];
    stim_row_t      stim_table[$];
    int             errors;
    bit             quiet;

    bit          ent_v[4][64];
    logic [11:0] ent_ctx[4][64];
    logic [19:0] ent_tag[4][64];
    logic [31:0] ent_pte[4][64];
    logic [35:0] ent_addr[4][64];
    int          vic[4];
    int          vic3[16];

    multi_level_page_tlb u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int tag_width(int lvl);
        return lvl == 0 ? 0 : lvl == 1 ? mlpt_pkg::L1_TAG_W
                            : lvl == 2 ? mlpt_pkg::L2_TAG_W : mlpt_pkg::L3_TAG_W;
    endfunction

    function automatic logic [19:0] tag_of(logic [31:0] va, int lvl);
        return lvl == 0 ? 20'd0 : 20'(va >> (32 - tag_width(lvl)));
    endfunction

    function automatic int bank_depth(int lvl);
        return lvl == 0 ? mlpt_pkg::L0_DEPTH : lvl == 1 ? mlpt_pkg::L1_DEPTH
                        : lvl == 2 ? mlpt_pkg::L2_DEPTH
                        : mlpt_pkg::L3_SET_COUNT * mlpt_pkg::L3_WAY_COUNT;
    endfunction

    function automatic int slot_find(int lvl, int base, int cnt, logic [11:0] ctx,
                                     logic [19:0] tag);
        for (int i = base; i < base + cnt; i++)
            if (ent_v[lvl][i] && ent_ctx[lvl][i] == ctx && ent_tag[lvl][i] == tag)
                return i;
        return -1;
    endfunction

    function automatic void tlb_clear();
        for (int l = 0; l < 4; l++)
        begin
            vic[l] = 0;
            for (int i = 0; i < 64; i++)
                ent_v[l][i] = 1'b0;
        end
        for (int s = 0; s < 16; s++)
            vic3[s] = 0;
    endfunction

    function automatic mlpt_pkg::rsp_t tlb_predict(mlpt_pkg::req_t r);
        mlpt_pkg::rsp_t o;
        int             set;
        int             lvl;
        int             base;
        int             cnt;
        int             idx;
        int             slot;
        int             fb;
        int             tb;
        int             n;
        bit             glob;
        bit             ctx_eq;
        bit             va_ok;
        bit             kill;
        o    = '0;
        set  = int'(r.va[15:12]);
        lvl  = int'(r.level);
        base = lvl == 3 ? set * mlpt_pkg::L3_WAY_COUNT : 0;
        cnt  = lvl == 3 ? mlpt_pkg::L3_WAY_COUNT : bank_depth(lvl);
        case (mlpt_pkg::op_e_t'(r.op))
            mlpt_pkg::OP_LOOKUP:
            begin
                for (int l = 0; l < 4; l++)
                begin
                    idx = slot_find(l, l == 3 ? set * mlpt_pkg::L3_WAY_COUNT : 0,
                                    l == 3 ? mlpt_pkg::L3_WAY_COUNT : bank_depth(l),
                                    r.context_req, tag_of(r.va, l));
                    if (idx >= 0)
                    begin
                        o.hit            = 1'b1;
                        o.found_pte      = ent_pte[l][idx];
                        o.found_level    = 2'(l);
                        o.found_pte_addr = ent_addr[l][idx];
                        break;
                    end
                end
            end
            mlpt_pkg::OP_INSERT:
            begin
                slot = -1;
                for (int i = base; i < base + cnt; i++)
                    if (!ent_v[lvl][i])
                    begin
                        slot = i;
                        break;
                    end
                if (slot < 0)
                begin
                    if (lvl == 3)
                    begin
                        slot      = base + vic3[set];
                        vic3[set] = (vic3[set] + 1) % cnt;
                    end
                    else
                    begin
                        slot     = vic[lvl];
                        vic[lvl] = (vic[lvl] + 1) % cnt;
                    end
                end
                ent_v[lvl][slot]    = 1'b1;
                ent_ctx[lvl][slot]  = r.context_req;
                ent_tag[lvl][slot]  = tag_of(r.va, lvl);
                ent_pte[lvl][slot]  = r.pte_value;
                ent_addr[lvl][slot] = r.pte_addr;
            end
            mlpt_pkg::OP_UPDATE:
            begin
                idx = slot_find(lvl, base, cnt, r.context_req, tag_of(r.va, lvl));
                if (idx >= 0)
                    ent_pte[lvl][idx] = r.pte_value;
            end
            default:
            begin
                if (r.flush_type == mlpt_pkg::FL_ENTIRE)
                    tlb_clear();
                else if (r.flush_type <= mlpt_pkg::FL_CONTEXT)
                begin
                    fb = r.flush_type == mlpt_pkg::FL_PAGE ? 20
                       : r.flush_type == mlpt_pkg::FL_SEGMENT ? 14 : 8;
                    for (int l = 0; l < 4; l++)
                    begin
                        tb = tag_width(l);
                        n  = fb < tb ? fb : tb;
                        for (int i = 0; i < bank_depth(l); i++)
                        begin
                            if (!ent_v[l][i])
                                continue;
                            glob   = ent_pte[l][i][4:2] >= 3'(mlpt_pkg::ACC_GLOBAL_MIN);
                            ctx_eq = ent_ctx[l][i] == r.context_req;
                            if (r.flush_type == mlpt_pkg::FL_CONTEXT)
                                kill = !glob && ctx_eq;
                            else
                            begin
                                va_ok = n == 0 ||
                                        (r.va >> (32 - n)) == (32'(ent_tag[l][i]) >> (tb - n));
                                kill  = (glob || ctx_eq) && va_ok;
                            end
                            if (kill)
                                ent_v[l][i] = 1'b0;
                        end
                    end
                end
            end
        endcase
        return o;
    endfunction

    function automatic mlpt_pkg::req_t mk_req(mlpt_pkg::op_e_t op, logic [31:0] va,
                                              logic [11:0] ctx, logic [31:0] pte,
                                              logic [1:0] lvl, logic [35:0] addr,
                                              logic [2:0] ft);
        mlpt_pkg::req_t r;
        r.op          = op;
        r.va          = va;
        r.context_req = ctx;
        r.pte_value   = pte;
        r.level       = lvl;
        r.pte_addr    = addr;
        r.flush_type  = ft;
        return r;
    endfunction

    task automatic add_row(mlpt_pkg::req_t r, bit typed, mlpt_pkg::rsp_t want);
        stim_row_t row;
        row.beat  = r;
        row.typed = typed;
        row.want  = want;
        stim_table.push_back(row);
    endtask

    task automatic send_beat(mlpt_pkg::req_t r, bit typed, mlpt_pkg::rsp_t want, bit may_idle);
        mlpt_pkg::rsp_t pred;
        if (may_idle && !quiet && $urandom_range(99) < 22)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pred = tlb_predict(r);
        expected_rsp_q.push_back(typed ? want : pred);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= quiet || $urandom_range(99) >= 22;
    end

    always @(posedge clk)
    begin
        mlpt_pkg::rsp_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $realtime, rsp);
                errors++;
            end
            else
            begin
                e = expected_rsp_q.pop_front();
                if (rsp.hit !== e.hit)
                begin
                    $display("%0t: hit exp %h got %h", $realtime, e.hit, rsp.hit);
                    errors++;
                end
                if (rsp.found_pte !== e.found_pte)
                begin
                    $display("%0t: found_pte exp %h got %h", $realtime, e.found_pte,
                             rsp.found_pte);
                    errors++;
                end
                if (rsp.found_level !== e.found_level)
                begin
                    $display("%0t: found_level exp %h got %h", $realtime, e.found_level,
                             rsp.found_level);
                    errors++;
                end
                if (rsp.found_pte_addr !== e.found_pte_addr)
                begin
                    $display("%0t: found_pte_addr exp %h got %h", $realtime, e.found_pte_addr,
                             rsp.found_pte_addr);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("** multi_level_page_tlb: FAILED **");
        $finish;
    end

    initial
    begin
        mlpt_pkg::rsp_t z;
        mlpt_pkg::rsp_t h;
        mlpt_pkg::req_t r;
        logic [31:0]    va_pool[8];
        logic [11:0]    ctx_pool[4];
        int             pick;
        errors    = 0;
        quiet     = 1'b0;
        z         = '0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        tlb_clear();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        add_row(mk_req(mlpt_pkg::OP_LOOKUP, 32'h0, 12'h0, 32'h0, 2'd0, 36'h0,
                       mlpt_pkg::FL_PAGE), 1, z);
        add_row(mk_req(mlpt_pkg::OP_INSERT, 32'hFFFFF000, 12'hFFF, 32'hFFFFFFFF, 2'd3,
                       36'hFFFFFFFFF, mlpt_pkg::FL_PAGE), 1, z);
        h = '{1'b1, 32'hFFFFFFFF, 2'd3, 36'hFFFFFFFFF};
        add_row(mk_req(mlpt_pkg::OP_LOOKUP, 32'hFFFFFFFF, 12'hFFF, 32'h0, 2'd0, 36'h0,
                       mlpt_pkg::FL_PAGE), 1, h);
        add_row(mk_req(mlpt_pkg::OP_INSERT, 32'h0, 12'h005, 32'h18, 2'd0, 36'h123,
                       mlpt_pkg::FL_PAGE), 1, z);
        h = '{1'b1, 32'h18, 2'd0, 36'h123};
        add_row(mk_req(mlpt_pkg::OP_LOOKUP, 32'h89ABCDEF, 12'h005, 32'h0, 2'd0, 36'h0,
                       mlpt_pkg::FL_PAGE), 1, h);
        add_row(mk_req(mlpt_pkg::OP_UPDATE, 32'h0, 12'h005, 32'hABCD0000, 2'd0, 36'h0,
                       mlpt_pkg::FL_PAGE), 1, z);
        add_row(mk_req(mlpt_pkg::OP_LOOKUP, 32'h0, 12'h005, 32'h0, 2'd0, 36'h0,
                       mlpt_pkg::FL_PAGE), 0, z);
        add_row(mk_req(mlpt_pkg::OP_INSERT, 32'h12345678, 12'h007, 32'h4, 2'd1, 36'h800000001,
                       mlpt_pkg::FL_PAGE), 0, z);
        add_row(mk_req(mlpt_pkg::OP_INSERT, 32'h12345678, 12'h007, 32'h8, 2'd2, 36'h2,
                       mlpt_pkg::FL_PAGE), 0, z);
        add_row(mk_req(mlpt_pkg::OP_LOOKUP, 32'h12345678, 12'h007, 32'h0, 2'd0, 36'h0,
                       mlpt_pkg::FL_PAGE), 0, z);
        add_row(mk_req(mlpt_pkg::OP_FLUSH, 32'h12000000, 12'h007, 32'h0, 2'd0, 36'h0,
                       mlpt_pkg::FL_REGION), 1, z);
        add_row(mk_req(mlpt_pkg::OP_LOOKUP, 32'h12345678, 12'h007, 32'h0, 2'd0, 36'h0,
                       mlpt_pkg::FL_PAGE), 0, z);
        add_row(mk_req(mlpt_pkg::OP_UPDATE, 32'h55555555, 12'h0AA, 32'h1, 2'd3, 36'h0,
                       mlpt_pkg::FL_PAGE), 1, z);
        add_row(mk_req(mlpt_pkg::OP_FLUSH, 32'h0, 12'h005, 32'h0, 2'd0, 36'h0, 3'd5), 1, z);
        add_row(mk_req(mlpt_pkg::OP_FLUSH, 32'h0, 12'h005, 32'h0, 2'd0, 36'h0,
                       mlpt_pkg::FL_CONTEXT), 1, z);
        add_row(mk_req(mlpt_pkg::OP_LOOKUP, 32'h0, 12'h005, 32'h0, 2'd0, 36'h0,
                       mlpt_pkg::FL_PAGE), 0, z);
        add_row(mk_req(mlpt_pkg::OP_FLUSH, 32'hFFFFF000, 12'h000, 32'h0, 2'd0, 36'h0,
                       mlpt_pkg::FL_PAGE), 1, z);
        add_row(mk_req(mlpt_pkg::OP_FLUSH, 32'hFFFC0000, 12'h000, 32'h0, 2'd0, 36'h0,
                       mlpt_pkg::FL_SEGMENT), 1, z);
        for (int i = 0; i < 5; i++)
            add_row(mk_req(mlpt_pkg::OP_INSERT, 32'h00010000 * (i + 1), 12'h001, 32'h100 + i,
                           2'd3, 36'h10 + i, mlpt_pkg::FL_PAGE), 1, z);
        add_row(mk_req(mlpt_pkg::OP_LOOKUP, 32'h00010000, 12'h001, 32'h0, 2'd0, 36'h0,
                       mlpt_pkg::FL_PAGE), 0, z);
        add_row(mk_req(mlpt_pkg::OP_FLUSH, 32'h0, 12'h000, 32'h0, 2'd0, 36'h0,
                       mlpt_pkg::FL_ENTIRE), 1, z);
        add_row(mk_req(mlpt_pkg::OP_LOOKUP, 32'hFFFFFFFF, 12'hFFF, 32'h0, 2'd0, 36'h0,
                       mlpt_pkg::FL_PAGE), 1, z);
        foreach (stim_table[i])
            send_beat(stim_table[i].beat, stim_table[i].typed, stim_table[i].want, 1);

        // random traffic over small pools so that hits and evictions are common
        for (int n = 0; n < 1250; n++)
        begin
            if (n % 300 == 0)
            begin
                foreach (va_pool[i])
                    va_pool[i] = $urandom;
                foreach (ctx_pool[i])
                    ctx_pool[i] = 12'($urandom);
                ctx_pool[0] = 12'h000;
                ctx_pool[1] = 12'hFFF;
            end
            quiet = n >= 500 && n < 700;
            if (n == 800)
            begin
                req_valid <= 1'b0;
                while (expected_rsp_q.size() != 0)
                    @(posedge clk);
            end
            r.va          = $urandom_range(99) < 80 ? va_pool[$urandom_range(7)] : $urandom;
            if ($urandom_range(1))
                r.va[11:0] = 12'($urandom);
            r.context_req = $urandom_range(99) < 80 ? ctx_pool[$urandom_range(3)]
                                                    : 12'($urandom);
            r.pte_value   = $urandom;
            if ($urandom_range(3) == 0)
                r.pte_value[4:2] = 3'($urandom_range(6, 7));
            r.level       = 2'($urandom);
            r.pte_addr    = {4'($urandom), 32'($urandom)};
            r.flush_type  = 3'($urandom);
            pick          = $urandom_range(99);
            if (pick < 40)
                r.op = mlpt_pkg::OP_LOOKUP;
            else if (pick < 72)
                r.op = mlpt_pkg::OP_INSERT;
            else if (pick < 88)
                r.op = mlpt_pkg::OP_UPDATE;
            else
            begin
                r.op = mlpt_pkg::OP_FLUSH;
                if (r.flush_type == mlpt_pkg::FL_ENTIRE && $urandom_range(2) != 0)
                    r.flush_type = 3'($urandom_range(0, 3));
            end
            send_beat(r, 0, z, 1);
        end
        req_valid <= 1'b0;
        quiet = 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("** multi_level_page_tlb: PASSED **");
        else
            $display("** multi_level_page_tlb: FAILED **");
        $finish;
    end
endmodule
